// ===== rtl/core/osd_pkg.sv =====
package osd_pkg;

   localparam int COUNT_BITS = 32;
   localparam int HASH_BITS = 64;
   localparam int BYTE_BITS = 8;
   localparam int TOTAL_BITS = 32;
   localparam int SEC_BITS = 17;
   localparam int STEP_BITS = 3;

   localparam logic [HASH_BITS-1:0] FNV_BASIS = 64'hCBF29CE484222325;

   typedef enum logic [1:0] {
      CMD_NAME   = 2'd0,
      CMD_WORD   = 2'd1,
      CMD_END    = 2'd2,
      CMD_FINISH = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WORD,
      ST_CNT,
      ST_SEC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_acc;
      logic load_word;
      logic step;
      logic use_ext;
   } fold_ctl_type;

   // One FNV-1a byte step. The prime is 2^40 + 0x1B3, so the product is a sum of shifts.
   function automatic logic [HASH_BITS-1:0] fnv_fold(input logic [HASH_BITS-1:0] h,
                                                     input logic [BYTE_BITS-1:0] b);
      logic [HASH_BITS-1:0] x;
      x = h ^ {{(HASH_BITS-BYTE_BITS){1'b0}}, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

// ===== rtl/core/osd_fold.sv =====
module osd_fold
   import osd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  fold_ctl_type         ctl,
   input  logic [HASH_BITS-1:0] acc_din,
   input  logic [HASH_BITS-1:0] word_din,
   input  logic [BYTE_BITS-1:0] ext_byte,
   output logic [HASH_BITS-1:0] acc_q
);

   logic [HASH_BITS-1:0] acc_ff, acc_in;
   logic [HASH_BITS-1:0] sh_ff, sh_in;
   logic [BYTE_BITS-1:0] byte_sel;

   assign byte_sel = ctl.use_ext ? ext_byte : sh_ff[BYTE_BITS-1:0];

   always_comb begin
      if (ctl.load_acc) begin
         acc_in = acc_din;
      end else if (ctl.step) begin
         acc_in = fnv_fold(acc_ff, byte_sel);
      end else begin
         acc_in = acc_ff;
      end
   end

   // A load takes priority; the step in the same cycle still uses the old low byte.
   always_comb begin
      if (ctl.load_word) begin
         sh_in = word_din;
      end else if (ctl.step) begin
         sh_in = sh_ff >> BYTE_BITS;
      end else begin
         sh_in = sh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= FNV_BASIS;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
   end

   assign acc_q = acc_ff;

endmodule

// ===== rtl/core/order_independent_state_digest_unit.sv =====
// Order-independent record digest built on 64-bit FNV-1a.
// Requests arrive on the req_ channel (valid/ready) with a command and its operands:
// a name byte, a 64-bit value word, end of record, or finish. Only finish produces
// a result on the rsp_ channel (valid/ready): the digest and the record total.
// A name byte and an end of record leave the block idle, so the next request can be
// accepted in the following cycle. A value word is folded one byte per cycle through
// a shift register and a single FNV byte-fold unit, so no new request is accepted until
// all eight bytes are folded. Finish folds the count and then the seconds of the day,
// 8 bytes each, through the same unit; the result is then written to the output
// register, which drives rsp_valid, rsp_digest and rsp_record_total directly.
// The result waits in an output register while new records are accepted; if a second
// finish completes before the first result is taken, the block holds until rsp_ready.
// Synchronous reset returns the record hash to the offset basis, clears the sum,
// the count and the output valid. Records not ended before finish are dropped.
module order_independent_state_digest_unit
   import osd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [BYTE_BITS-1:0]  req_name_byte,
   input  logic [HASH_BITS-1:0]  req_word_in,
   input  logic [SEC_BITS-1:0]   req_seconds_of_day,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [HASH_BITS-1:0]  rsp_digest,
   output logic [TOTAL_BITS-1:0] rsp_record_total
);

   state_type state_ff, state_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [HASH_BITS-1:0] sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SEC_BITS-1:0] sec_ff, sec_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [HASH_BITS-1:0] digest_ff, digest_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;

   fold_ctl_type ctl;
   logic [HASH_BITS-1:0] acc_din, word_din, acc_q;
   logic req_fire, last_step, emit_fire;
   cmd_type cmd;

   assign cmd = cmd_type'(req_cmd);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire = req_valid && req_ready;
   assign last_step = (cnt_ff == {STEP_BITS{1'b1}});
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   osd_fold u_fold (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .acc_din  (acc_din),
      .word_din (word_din),
      .ext_byte (req_name_byte),
      .acc_q    (acc_q)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_WORD:   state_in = ST_WORD;
                  CMD_FINISH: state_in = ST_CNT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_WORD: if (last_step) state_in = ST_IDLE;
         ST_CNT:  if (last_step) state_in = ST_SEC;
         ST_SEC:  if (last_step) state_in = ST_EMIT;
         ST_EMIT: if (emit_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      acc_din = FNV_BASIS;
      word_din = req_word_in;
      sum_in = sum_ff;
      count_in = count_ff;
      sec_in = sec_ff;
      cnt_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_NAME: begin
                     ctl.step = 1'b1;
                     ctl.use_ext = 1'b1;
                  end
                  CMD_WORD: begin
                     ctl.load_word = 1'b1;
                  end
                  CMD_END: begin
                     ctl.load_acc = 1'b1;
                     sum_in = sum_ff + acc_q;
                     count_in = count_ff + COUNT_BITS'(1);
                  end
                  CMD_FINISH: begin
                     ctl.load_acc = 1'b1;
                     acc_din = sum_ff;
                     ctl.load_word = 1'b1;
                     word_din = HASH_BITS'(count_ff);
                     sec_in = req_seconds_of_day;
                  end
                  default: ;
               endcase
            end
         end
         ST_WORD, ST_SEC: begin
            ctl.step = 1'b1;
            cnt_in = cnt_ff + STEP_BITS'(1);
         end
         ST_CNT: begin
            ctl.step = 1'b1;
            cnt_in = cnt_ff + STEP_BITS'(1);
            if (last_step) begin
               ctl.load_word = 1'b1;
               word_din = HASH_BITS'(sec_ff);
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               ctl.load_acc = 1'b1;
               sum_in = '0;
               count_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      digest_in = digest_ff;
      total_in = total_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         digest_in = acc_q;
         total_in = TOTAL_BITS'(count_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         sum_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sec_ff <= sec_in;
      digest_ff <= digest_in;
      total_ff <= total_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_digest = digest_ff;
   assign rsp_record_total = total_ff;

endmodule

// ===== rtl/core/osd_checker.sv =====
module osd_checker
   import osd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [1:0]            req_cmd,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [HASH_BITS-1:0]  rsp_digest,
   input logic [TOTAL_BITS-1:0] rsp_record_total
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest) && $stable(rsp_record_total))
      else $error("result changed while stalled");

   // A value word keeps the block busy while its bytes are folded.
   a_word_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_WORD |=> !req_ready)
      else $error("request accepted during word fold");

   // Finish keeps the block busy while the count and time are folded.
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_FINISH |=> !req_ready ##1 !req_ready)
      else $error("request accepted during finish fold");

   // Reset drops any pending result.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind order_independent_state_digest_unit osd_checker u_osd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_digest       (rsp_digest),
   .rsp_record_total (rsp_record_total)
);

// ===== tb/sv/tb_order_independent_state_digest_unit.sv =====
`timescale 1ns / 1ps

module tb_order_independent_state_digest_unit;
   import osd_pkg::*;

   localparam logic [HASH_BITS-1:0] HASH_MULTIPLIER = 64'd1099511628211;
   localparam int RANDOM_REQUESTS = 1950;
   localparam int IDLE_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [SEC_BITS-1:0] SECONDS_PER_DAY = 17'd86400;

   typedef struct packed {
      logic [HASH_BITS-1:0]  digest;
      logic [TOTAL_BITS-1:0] total;
   } digest_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_cmd = CMD_NAME;
   logic [BYTE_BITS-1:0]  req_name_byte = '0;
   logic [HASH_BITS-1:0]  req_word_in = '0;
   logic [SEC_BITS-1:0]   req_seconds_of_day = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [HASH_BITS-1:0]  rsp_digest;
   logic [TOTAL_BITS-1:0] rsp_record_total;

   // Predicted state of the digest unit.
   logic [HASH_BITS-1:0]  record_hash = FNV_BASIS;
   logic [HASH_BITS-1:0]  digest_sum = '0;
   logic [COUNT_BITS-1:0] record_count = '0;
   logic                  record_open = 1'b0;

   digest_result_type expected_digests[$];
   digest_result_type oldest_digest;

   int failures = 0;
   int requests_sent = 0;
   int digests_checked = 0;
   int records_ended = 0;
   int dropped_records = 0;
   int late_seconds = 0;
   int sender_burst = 0;
   int ready_hold = 0;
   int idle_cycles = 0;

   order_independent_state_digest_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_name_byte      (req_name_byte),
      .req_word_in        (req_word_in),
      .req_seconds_of_day (req_seconds_of_day),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest         (rsp_digest),
      .rsp_record_total   (rsp_record_total)
   );

   always #5 clock = ~clock;

   function automatic logic [HASH_BITS-1:0] fnv1a_byte(input logic [HASH_BITS-1:0] h,
                                                       input logic [BYTE_BITS-1:0] b);
      return (h ^ {{(HASH_BITS-BYTE_BITS){1'b0}}, b}) * HASH_MULTIPLIER;
   endfunction

   // Value words go in least significant byte first.
   function automatic logic [HASH_BITS-1:0] fnv1a_word(input logic [HASH_BITS-1:0] h,
                                                       input logic [HASH_BITS-1:0] w);
      logic [HASH_BITS-1:0] acc;
      acc = h;
      for (int k = 0; k < 8; k++) begin
         acc = fnv1a_byte(acc, w[8*k +: 8]);
      end
      return acc;
   endfunction

   function automatic void fold_request(input cmd_type cmd,
                                        input logic [BYTE_BITS-1:0] name_byte,
                                        input logic [HASH_BITS-1:0] word,
                                        input logic [SEC_BITS-1:0] sec);
      digest_result_type result;
      case (cmd)
         CMD_NAME: begin
            record_hash = fnv1a_byte(record_hash, name_byte);
            record_open = 1'b1;
         end
         CMD_WORD: begin
            record_hash = fnv1a_word(record_hash, word);
            record_open = 1'b1;
         end
         CMD_END: begin
            digest_sum = digest_sum + record_hash;
            record_count = record_count + COUNT_BITS'(1);
            record_hash = FNV_BASIS;
            record_open = 1'b0;
            records_ended++;
         end
         CMD_FINISH: begin
            result.digest = fnv1a_word(fnv1a_word(digest_sum, HASH_BITS'(record_count)),
                                       HASH_BITS'(sec));
            result.total = TOTAL_BITS'(record_count);
            expected_digests.push_back(result);
            // A record still open at finish is dropped along with the rest of the state.
            if (record_open) dropped_records++;
            if (sec >= SECONDS_PER_DAY) late_seconds++;
            record_hash = FNV_BASIS;
            digest_sum = '0;
            record_count = '0;
            record_open = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic logic [HASH_BITS-1:0] random_word();
      logic [HASH_BITS-1:0] w;
      case ($urandom_range(0, 7))
         0: w = '0;
         1: w = '1;
         2: w = 64'd1 << $urandom_range(0, 63);
         3: w = ~(64'd1 << $urandom_range(0, 63));
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   function automatic logic [SEC_BITS-1:0] random_seconds();
      if ($urandom_range(0, 9) == 0) return SEC_BITS'($urandom_range(86400, 131071));
      return SEC_BITS'($urandom_range(0, 86399));
   endfunction

   // Drives one request at a falling edge and holds it until the unit takes it.
   task automatic send_request(input cmd_type cmd, input logic [BYTE_BITS-1:0] name_byte,
                               input logic [HASH_BITS-1:0] word,
                               input logic [SEC_BITS-1:0] sec);
      int gap;
      if (sender_burst == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         sender_burst = $urandom_range(1, 30);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_name_byte <= name_byte;
      req_word_in <= word;
      req_seconds_of_day <= sec;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sender_burst--;
      requests_sent++;
      fold_request(cmd, name_byte, word, sec);
   endtask

   task automatic send_name(input logic [BYTE_BITS-1:0] b);
      send_request(CMD_NAME, b, random_word(), random_seconds());
   endtask

   task automatic send_word(input logic [HASH_BITS-1:0] w);
      send_request(CMD_WORD, 8'($urandom_range(0, 255)), w, random_seconds());
   endtask

   task automatic end_record();
      send_request(CMD_END, 8'($urandom_range(0, 255)), random_word(), random_seconds());
   endtask

   task automatic send_finish(input logic [SEC_BITS-1:0] sec);
      send_request(CMD_FINISH, 8'($urandom_range(0, 255)), random_word(), sec);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      sender_burst = 0;
      while (expected_digests.size() != 0) @(posedge clock);
   endtask

   task automatic test_no_records();
      send_finish('0);
      send_finish('1);
   endtask

   task automatic test_field_extremes();
      send_name(8'h00);
      send_name(8'hFF);
      send_word('0);
      send_word('1);
      end_record();
      send_word(64'h8000_0000_0000_0000);
      send_name(8'hA5);
      end_record();
      send_finish(17'd86399);
   endtask

   task automatic test_special_records();
      // Two empty records each add the offset basis, then an open record is dropped.
      end_record();
      end_record();
      send_name(8'h41);
      send_word(64'd1);
      send_finish(SECONDS_PER_DAY);
   endtask

   task automatic test_drain_pause();
      send_name(8'h5A);
      end_record();
      send_finish(17'd43200);
      wait_for_results();
      send_finish(17'd1);
   endtask

   task automatic test_random_records();
      int start_count;
      int n_records;
      int n_fields;
      start_count = requests_sent;
      while (requests_sent - start_count < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 11) == 0) begin
            send_request(cmd_type'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                         random_word(), SEC_BITS'($urandom_range(0, 131071)));
         end else begin
            n_records = $urandom_range(0, 6);
            repeat (n_records) begin
               n_fields = $urandom_range(0, 10);
               repeat (n_fields) begin
                  if ($urandom_range(0, 9) < 7) send_name(8'($urandom_range(0, 255)));
                  else send_word(random_word());
               end
               end_record();
            end
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(1, 4)) send_name(8'($urandom_range(0, 255)));
            end
            send_finish(random_seconds());
            if ($urandom_range(0, 19) == 0) wait_for_results();
         end
      end
   endtask

   // The receiver alternates ready runs with stalls, mostly short and now and then long.
   always @(negedge clock) begin
      if (ready_hold != 0) begin
         ready_hold--;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
         ready_hold = $urandom_range(0, 40);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_digests.size() == 0) begin
            $error("unexpected digest %h with record_total %0d", rsp_digest, rsp_record_total);
            failures++;
         end else begin
            oldest_digest = expected_digests.pop_front();
            digests_checked++;
            if (rsp_digest !== oldest_digest.digest) begin
               $error("digest: expected %h, got %h", oldest_digest.digest, rsp_digest);
               failures++;
            end
            if (rsp_record_total !== oldest_digest.total) begin
               $error("record_total: expected %0d, got %0d", oldest_digest.total,
                      rsp_record_total);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("order_independent_state_digest_unit regression: fail");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_no_records();
      test_field_extremes();
      test_special_records();
      test_drain_pause();
      test_random_records();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_digests.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d requests sent, %0d records ended, %0d digests checked", requests_sent,
               records_ended, digests_checked);
      $display("%0d open records dropped at finish, %0d finishes past the end of day",
               dropped_records, late_seconds);
      if (failures == 0) begin
         $display("order_independent_state_digest_unit regression: pass");
      end else begin
         $display("order_independent_state_digest_unit regression: fail");
      end
      $finish;
   end

endmodule
